// ===== hw/rtl/arpr_pkg.sv =====
// ----------------------------------------------------------------------------
// arpr_pkg: shared types and constants for the ARP responder
// Holds the command and result records, code enums and the cache hash.
// ----------------------------------------------------------------------------
package arpr_pkg;

  localparam int MAC_W      = 48;
  localparam int IP_W       = 32;
  localparam int TBL_DEPTH  = 256;
  localparam int IDX_W      = $clog2(TBL_DEPTH);
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic [15:0]      HW_TYPE_ETH    = 16'h0001;
  localparam logic [15:0]      PROTO_IPV4     = 16'h0800;
  localparam logic [7:0]       HW_LEN_ETH     = 8'd6;
  localparam logic [7:0]       PROTO_LEN_IPV4 = 8'd4;
  localparam logic [15:0]      ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0]      ARP_OP_REPLY   = 16'd2;
  localparam logic [MAC_W-1:0] BCAST_MAC      = {MAC_W{1'b1}};

  // configuration register indexes
  localparam logic CFG_OWN_MAC = 1'b0;
  localparam logic CFG_OWN_IP  = 1'b1;

  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_SEND   = 2'd2
  } operation_t;

  typedef enum logic [1:0] {
    OUT_OP_NONE    = 2'd0,
    OUT_OP_REQUEST = 2'd1,
    OUT_OP_REPLY   = 2'd2
  } out_opcode_t;

  typedef enum logic [2:0] {
    RK_NONE    = 3'd0,
    RK_REPLY   = 3'd1,
    RK_REQUEST = 3'd2,
    RK_HIT     = 3'd3,
    RK_MISS    = 3'd4
  } result_kind_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LEARN,
    CMD_REPLY,
    CMD_LOOKUP,
    CMD_REQUEST
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_FIN
  } back_state_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
  } arpr_cmd_t;

  typedef struct packed {
    result_kind_t     kind;
    logic [MAC_W-1:0] eth_dest_mac;
    out_opcode_t      opcode;
    logic [MAC_W-1:0] target_mac;
    logic [IP_W-1:0]  target_ip;
  } arpr_result_t;

  // queue status seen by the front and back halves
  typedef struct packed {
    logic full;
    logic empty;
  } arpr_qstat_t;

  function automatic logic [IDX_W-1:0] hash_ip(input logic [IP_W-1:0] ip);
    return ip[7:0] ^ ip[15:8] ^ ip[23:16] ^ ip[31:24];
  endfunction

endpackage

// ===== hw/rtl/arpr_front.sv =====
// ----------------------------------------------------------------------------
// arpr_front: input classifier
// Checks the ARP header, picks the command kind and cache index, holds own_ip.
// ----------------------------------------------------------------------------
module arpr_front
  import arpr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [MAC_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [1:0]       operation,
  input  logic [15:0]      hw_type,
  input  logic [15:0]      proto_type,
  input  logic [7:0]       hw_len,
  input  logic [7:0]       proto_len,
  input  logic [15:0]      arp_opcode,
  input  logic [MAC_W-1:0] sender_mac,
  input  logic [IP_W-1:0]  sender_ip,
  input  logic [IP_W-1:0]  target_ip,
  input  logic [IP_W-1:0]  query_ip,
  input  arpr_qstat_t      q_stat,
  output logic             push,
  output arpr_cmd_t        cmd
);

  logic [IP_W-1:0] own_ip_r;
  logic [IP_W-1:0] own_ip_nxt;
  logic            hdr_ok;
  logic            opc_ok;

  // own_mac never reaches a result field, so only own_ip is held
  always_comb begin
    own_ip_nxt = own_ip_r;
    if (cfg_we && (cfg_addr == CFG_OWN_IP)) begin
      own_ip_nxt = cfg_wdata[IP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r <= '0;
    end else begin
      own_ip_r <= own_ip_nxt;
    end
  end

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;

  assign hdr_ok = (hw_type == HW_TYPE_ETH) && (hw_len == HW_LEN_ETH) &&
                  (proto_type == PROTO_IPV4) && (proto_len == PROTO_LEN_IPV4);
  assign opc_ok = (arp_opcode == ARP_OP_REQUEST) || (arp_opcode == ARP_OP_REPLY);

  always_comb begin
    cmd      = '0;
    cmd.kind = CMD_NOP;
    unique case (operation)
      OP_PACKET: begin
        cmd.idx = hash_ip(sender_ip);
        cmd.mac = sender_mac;
        cmd.ip  = sender_ip;
        if (hdr_ok && opc_ok) begin
          if ((arp_opcode == ARP_OP_REQUEST) && (target_ip == own_ip_r)) begin
            cmd.kind = CMD_REPLY;
          end else begin
            cmd.kind = CMD_LEARN;
          end
        end
      end
      OP_LOOKUP: begin
        cmd.kind = CMD_LOOKUP;
        cmd.idx  = hash_ip(query_ip);
        cmd.ip   = query_ip;
      end
      OP_SEND: begin
        cmd.kind = CMD_REQUEST;
        cmd.ip   = query_ip;
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

endmodule

// ===== hw/rtl/arpr_cmdq.sv =====
// ----------------------------------------------------------------------------
// arpr_cmdq: command queue
// Two-entry FIFO that decouples the classifier from the cache engine.
// ----------------------------------------------------------------------------
module arpr_cmdq
  import arpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  arpr_cmd_t   push_cmd,
  input  logic        pop,
  output arpr_cmd_t   head,
  output arpr_qstat_t stat
);

  arpr_cmd_t             ent_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full && !pop))
    else $error("command pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("command popped from empty queue");

endmodule

// ===== hw/rtl/arpr_back.sv =====
// ----------------------------------------------------------------------------
// arpr_back: cache engine
// Runs one command at a time against the 256-entry cache, builds result.
// ----------------------------------------------------------------------------
module arpr_back
  import arpr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  arpr_qstat_t  q_stat,
  input  arpr_cmd_t    head,
  output logic         pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output arpr_result_t out_res
);

  back_state_t          st_r, st_nxt;
  arpr_cmd_t            cmd_r;
  logic [TBL_DEPTH-1:0] vld_r;
  logic [IP_W-1:0]      ip_mem  [TBL_DEPTH];
  logic [MAC_W-1:0]     mac_mem [TBL_DEPTH];
  logic [IP_W-1:0]      ip_rd_r;
  logic [MAC_W-1:0]     mac_rd_r;
  logic                 vld_rd_r;
  logic                 wr_en;
  logic                 load;
  logic                 hit;
  arpr_result_t         res;
  logic                 out_valid_r, out_valid_nxt;
  arpr_result_t         out_res_r;

  always_comb begin
    st_nxt = st_r;
    pop    = 1'b0;
    load   = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop    = 1'b1;
          st_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        if (!out_valid_r || out_tready) begin
          load   = 1'b1;
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign wr_en = pop && ((head.kind == CMD_LEARN) || (head.kind == CMD_REPLY));

  // entry valid bits: cleared by reset, set on first write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[head.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_mem[head.idx]  <= head.ip;
      mac_mem[head.idx] <= head.mac;
    end
  end

  // read on pop; hold read data while the result waits
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r    <= head;
      ip_rd_r  <= ip_mem[head.idx];
      mac_rd_r <= mac_mem[head.idx];
      vld_rd_r <= vld_r[head.idx];
    end
  end

  // an entry never written reads as IP 0, MAC 0
  assign hit = vld_rd_r ? (ip_rd_r == cmd_r.ip) : (cmd_r.ip == '0);

  always_comb begin
    res        = '0;
    res.kind   = RK_NONE;
    res.opcode = OUT_OP_NONE;
    case (cmd_r.kind)
      CMD_REPLY: begin
        res.kind         = RK_REPLY;
        res.eth_dest_mac = cmd_r.mac;
        res.opcode       = OUT_OP_REPLY;
        res.target_mac   = cmd_r.mac;
        res.target_ip    = cmd_r.ip;
      end
      CMD_REQUEST: begin
        res.kind         = RK_REQUEST;
        res.eth_dest_mac = BCAST_MAC;
        res.opcode       = OUT_OP_REQUEST;
        res.target_mac   = BCAST_MAC;
        res.target_ip    = cmd_r.ip;
      end
      CMD_LOOKUP: begin
        res.target_ip = cmd_r.ip;
        if (hit) begin
          res.kind       = RK_HIT;
          res.target_mac = vld_rd_r ? mac_rd_r : '0;
        end else begin
          res.kind = RK_MISS;
        end
      end
      default: begin
        res.kind = RK_NONE;
      end
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

  a_pop_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (st_r == BK_FIN))
    else $error("popped command did not enter finish state");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("loaded result not presented");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.kind == RK_NONE)) |->
      ((out_res_r.eth_dest_mac == '0) && (out_res_r.target_mac == '0) &&
       (out_res_r.target_ip == '0) && (out_res_r.opcode == OUT_OP_NONE)))
    else $error("empty result carries data");

endmodule

// ===== hw/rtl/arp_responder_with_hashed_cache_core.sv =====
// ----------------------------------------------------------------------------
// arp_responder_with_hashed_cache_core: ARP responder with hashed ARP cache
// Answers ARP requests for own_ip, learns senders, serves cache lookups.
// ----------------------------------------------------------------------------
// A word goes through the command queue, then the cache engine's read/write
// and result steps; the engine pops a new command only after the last result
//   is loaded, and the two-entry command queue absorbs bursts of two.
// Every accepted word gives exactly one result word (kind 0 for drops).
// Reset (rst_n low, synchronous) empties the queue, clears own_ip and clears
// all cache valid bits at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module arp_responder_with_hashed_cache_core
  import arpr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // configuration: index 0 own_mac, index 1 own_ip
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [47:0]  cfg_wdata,
  // input words
  input  logic         in_tvalid,
  output logic         in_tready,
  // [15:0] hw_type, [31:16] proto_type, [39:32] hw_len, [47:40] proto_len,
  // [63:48] arp_opcode, [111:64] sender_mac, [143:112] sender_ip,
  // [175:144] target_ip, [207:176] query_ip
  input  logic [207:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]   in_tuser,
  // result words
  output logic         out_tvalid,
  input  logic         out_tready,
  // [47:0] eth_dest_mac, [49:48] out_opcode, [97:50] target_mac,
  // [129:98] out_target_ip, [135:130] zero
  output logic [135:0] out_tdata,
  // [2:0] result_kind
  output logic [2:0]   out_tuser
);

  arpr_qstat_t  q_stat;
  arpr_cmd_t    push_cmd;
  arpr_cmd_t    head;
  logic         push;
  logic         pop;
  arpr_result_t res;

  // front: check header, classify, hash the address
  arpr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .operation  (in_tuser),
    .hw_type    (in_tdata[15:0]),
    .proto_type (in_tdata[31:16]),
    .hw_len     (in_tdata[39:32]),
    .proto_len  (in_tdata[47:40]),
    .arp_opcode (in_tdata[63:48]),
    .sender_mac (in_tdata[111:64]),
    .sender_ip  (in_tdata[143:112]),
    .target_ip  (in_tdata[175:144]),
    .query_ip   (in_tdata[207:176]),
    .q_stat     (q_stat),
    .push       (push),
    .cmd        (push_cmd)
  );

  // queue: lets the front keep taking words while a result is stalled
  arpr_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // back: cache write or read, result build, output register
  arpr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  // pack the result word, zero fill to a whole byte
  assign out_tdata = {6'd0, res.target_ip, res.target_mac, res.opcode, res.eth_dest_mac};
  assign out_tuser = res.kind;

endmodule

// ===== bench/tb_arp_responder_with_hashed_cache_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arp_responder_with_hashed_cache_core: self-checking bench for the core
// Feeds parsed ARP packets, cache lookups and send requests through the input
// stream, predicts every result word with a local copy of the ARP cache and
// compares each field of each result word in order, under random idling and
// back-pressure on both streams and several own_mac / own_ip settings.
// ----------------------------------------------------------------------------
module tb_arp_responder_with_hashed_cache_core;
  import arpr_pkg::*;

  // operation code 3 is not used by the block; it must come back as kind 0
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // cycles without any accepted word before the run is given up
  localparam int QUIET_LIMIT = 1000;
  // length of the long receiver hold-off that backs up the input stream
  localparam int HOLD_OFF_CYCLES = 80;

  // one input word, fields as the block sees them
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] arp_op;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
  } arp_word_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic         cfg_addr = CFG_OWN_MAC;
  logic [47:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [207:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic [2:0]   out_tuser;

  // words still to be sent, and result words still owed by the block
  arp_word_t    word_q[$];
  arpr_result_t reply_due_q[$];

  // local copy of the ARP cache and of the interface registers
  logic [31:0]  learned_ip  [256];
  logic [47:0]  learned_mac [256];
  logic [47:0]  my_mac;
  logic [31:0]  my_ip;

  // addresses that the random words keep coming back to, so lookups hit
  logic [31:0]  ip_pool [16];

  int           err_count = 0;
  int           quiet_cycles = 0;
  int           send_gap = 0;
  int           recv_gap = 0;
  int           hold_off_left = 0;
  bit           idle_on = 1'b0;
  logic         offer_next;
  logic         ready_next;
  arpr_result_t due;

  arp_responder_with_hashed_cache_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // [15:0] hw_type, [31:16] proto_type, [39:32] hw_len, [47:40] proto_len,
    // [63:48] arp_opcode, [111:64] sender_mac, [143:112] sender_ip,
    // [175:144] target_ip, [207:176] query_ip
    .in_tdata   (in_tdata),
    // [1:0] operation
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // [47:0] eth_dest_mac, [49:48] out_opcode, [97:50] target_mac,
    // [129:98] out_target_ip, [135:130] zero
    .out_tdata  (out_tdata),
    // [2:0] result_kind
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction: apply one accepted word to the local cache and return the
  // result word the block owes for it.
  // --------------------------------------------------------------------------
  function automatic arpr_result_t resolve_arp_word(input arp_word_t w);
    arpr_result_t r;
    logic [7:0]   slot;
    r = '0;
    case (w.op)
      OP_PACKET: begin
        // drop anything that is not Ethernet/IPv4 ARP with a known opcode
        if (w.hw_type == HW_TYPE_ETH && w.proto_type == PROTO_IPV4 &&
            w.hw_len == HW_LEN_ETH && w.proto_len == PROTO_LEN_IPV4 &&
            (w.arp_op == ARP_OP_REQUEST || w.arp_op == ARP_OP_REPLY)) begin
          slot = w.sender_ip[7:0] ^ w.sender_ip[15:8] ^
                 w.sender_ip[23:16] ^ w.sender_ip[31:24];
          learned_ip[slot]  = w.sender_ip;
          learned_mac[slot] = w.sender_mac;
          // answer only requests aimed at this interface
          if (w.arp_op == ARP_OP_REQUEST && w.target_ip == my_ip) begin
            r.kind         = RK_REPLY;
            r.eth_dest_mac = w.sender_mac;
            r.opcode       = OUT_OP_REPLY;
            r.target_mac   = w.sender_mac;
            r.target_ip    = w.sender_ip;
          end
        end
      end
      OP_LOOKUP: begin
        slot = w.query_ip[7:0] ^ w.query_ip[15:8] ^
               w.query_ip[23:16] ^ w.query_ip[31:24];
        r.target_ip = w.query_ip;
        if (learned_ip[slot] == w.query_ip) begin
          r.kind       = RK_HIT;
          r.target_mac = learned_mac[slot];
        end else begin
          r.kind = RK_MISS;
        end
      end
      OP_SEND: begin
        r.kind         = RK_REQUEST;
        r.eth_dest_mac = BCAST_MAC;
        r.opcode       = OUT_OP_REQUEST;
        r.target_mac   = BCAST_MAC;
        r.target_ip    = w.query_ip;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    err_count++;
    $display("%0t: mismatch in %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // mostly pool addresses so that learned entries get looked up again
  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 4) != 0)
      return ip_pool[$urandom_range(0, 15)];
    return 32'($urandom);
  endfunction

  function automatic arp_word_t arp_packet(input logic [15:0] opc,
                                           input logic [47:0] smac,
                                           input logic [31:0] sip,
                                           input logic [31:0] tip);
    arp_word_t w;
    w.op         = OP_PACKET;
    w.hw_type    = HW_TYPE_ETH;
    w.proto_type = PROTO_IPV4;
    w.hw_len     = HW_LEN_ETH;
    w.proto_len  = PROTO_LEN_IPV4;
    w.arp_op     = opc;
    w.sender_mac = smac;
    w.sender_ip  = sip;
    w.target_ip  = tip;
    w.query_ip   = 32'($urandom);
    return w;
  endfunction

  function automatic arp_word_t arp_query(input logic [1:0] opc,
                                          input logic [31:0] qip);
    arp_word_t w;
    // fill the ignored packet fields with noise
    w = arp_packet(16'($urandom), rand_mac(), 32'($urandom), 32'($urandom));
    w.op       = opc;
    w.query_ip = qip;
    return w;
  endfunction

  // mostly well-formed traffic with random content, the rest broken headers,
  // pure noise and the unused operation code
  function automatic arp_word_t random_word();
    arp_word_t w;
    int        roll;
    roll = $urandom_range(0, 99);
    w = arp_packet($urandom_range(0, 1) ? ARP_OP_REQUEST : ARP_OP_REPLY,
                   rand_mac(), pick_ip(),
                   $urandom_range(0, 1) ? my_ip : pick_ip());
    w.query_ip = pick_ip();
    if (roll < 45) begin
      // keep the valid packet
    end else if (roll < 70) begin
      w.op = OP_LOOKUP;
    end else if (roll < 80) begin
      w.op = OP_SEND;
    end else if (roll < 92) begin
      // break one header field
      case ($urandom_range(0, 4))
        0: w.hw_type    = 16'($urandom);
        1: w.proto_type = 16'($urandom);
        2: w.hw_len     = 8'($urandom);
        3: w.proto_len  = 8'($urandom);
        default: w.arp_op = 16'($urandom);
      endcase
    end else if (roll < 97) begin
      w.op         = 2'($urandom_range(0, 3));
      w.hw_type    = 16'($urandom);
      w.proto_type = 16'($urandom);
      w.hw_len     = 8'($urandom);
      w.proto_len  = 8'($urandom);
      w.arp_op     = 16'($urandom);
      w.sender_ip  = 32'($urandom);
      w.target_ip  = 32'($urandom);
      w.query_ip   = 32'($urandom);
    end else begin
      w.op = OP_UNUSED;
    end
    return w;
  endfunction

  // new pool: the upper half repeats the lower half byte-reversed, which
  // lands on the same cache slot and forces overwrites
  task automatic refresh_pool();
    for (int i = 0; i < 8; i++) begin
      ip_pool[i]     = 32'($urandom);
      ip_pool[i + 8] = {ip_pool[i][7:0], ip_pool[i][15:8],
                        ip_pool[i][23:16], ip_pool[i][31:24]};
    end
  endtask

  // write one register; only called while the block is idle
  task automatic write_reg(input logic idx, input logic [47:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OWN_MAC)
      my_mac = value;
    else
      my_ip = value[31:0];
  endtask

  // hold the sender until every owed result word is back, then settle
  task automatic wait_drained();
    @(negedge clk);
    while (word_q.size() != 0 || reply_due_q.size() != 0 || in_tvalid)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++)
      word_q.push_back(random_word());
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the oldest pending word, predict it when it is taken,
  // and insert random gaps between words while idling is on.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        reply_due_q.push_back(resolve_arp_word(word_q.pop_front()));
        offer_next = 1'b0;
      end else begin
        // hold a word that has not been taken yet
        offer_next = in_tvalid;
      end
      if (!offer_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (word_q.size() != 0) begin
          if (idle_on && $urandom_range(0, 3) == 0)
            send_gap = $urandom_range(0, 18);
          else
            offer_next = 1'b1;
        end
      end
      in_tvalid <= offer_next;
      if (offer_next) begin
        in_tdata <= {word_q[0].query_ip, word_q[0].target_ip, word_q[0].sender_ip,
                     word_q[0].sender_mac, word_q[0].arp_op, word_q[0].proto_len,
                     word_q[0].hw_len, word_q[0].proto_type, word_q[0].hw_type};
        in_tuser <= word_q[0].op;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each taken result word against the oldest expectation and
  // drive out_tready with random stalls and the long hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (reply_due_q.size() == 0) begin
          flag_mismatch("unexpected result word", 64'(out_tuser), 64'(0));
        end else begin
          due = reply_due_q.pop_front();
          if (out_tuser !== due.kind)
            flag_mismatch("result_kind", 64'(out_tuser), 64'(due.kind));
          if (out_tdata[47:0] !== due.eth_dest_mac)
            flag_mismatch("eth_dest_mac", 64'(out_tdata[47:0]), 64'(due.eth_dest_mac));
          if (out_tdata[49:48] !== due.opcode)
            flag_mismatch("out_opcode", 64'(out_tdata[49:48]), 64'(due.opcode));
          if (out_tdata[97:50] !== due.target_mac)
            flag_mismatch("target_mac", 64'(out_tdata[97:50]), 64'(due.target_mac));
          if (out_tdata[129:98] !== due.target_ip)
            flag_mismatch("out_target_ip", 64'(out_tdata[129:98]), 64'(due.target_ip));
          if (out_tdata[135:130] !== 6'd0)
            flag_mismatch("tdata padding", 64'(out_tdata[135:130]), 64'(0));
        end
      end
      ready_next = 1'b1;
      if (hold_off_left > 0) begin
        hold_off_left--;
        ready_next = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        ready_next = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        recv_gap   = $urandom_range(0, 18);
        ready_next = 1'b0;
      end
      out_tready <= ready_next;
    end
  end

  // Watchdog: give up when no word moves on either stream for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_arp_responder_with_hashed_cache_core: errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin
    // reset clears the cache and both registers
    foreach (learned_ip[i]) begin
      learned_ip[i]  = '0;
      learned_mac[i] = '0;
    end
    my_mac = '0;
    my_ip  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_OWN_MAC, 48'h02_00_00_00_00_01);
    write_reg(CFG_OWN_IP, 48'h0000_C0A8_0001);

    // directed part; idling is on from the start
    idle_on = 1'b1;
    // a cleared slot holds 0.0.0.0 with MAC 0, so that lookup hits
    word_q.push_back(arp_query(OP_LOOKUP, 32'h0000_0000));
    word_q.push_back(arp_query(OP_LOOKUP, 32'hFFFF_FFFF));
    // request for us: reply to an all-ones sender
    word_q.push_back(arp_packet(ARP_OP_REQUEST, 48'hFFFF_FFFF_FFFF, 32'h0A00_0001, my_ip));
    // request for someone else: learn only, overwriting slot 0
    word_q.push_back(arp_packet(ARP_OP_REQUEST, 48'h0, 32'hFFFF_FFFF, 32'h0A00_0002));
    word_q.push_back(arp_query(OP_LOOKUP, 32'hFFFF_FFFF));
    word_q.push_back(arp_query(OP_LOOKUP, 32'h0000_0000));
    // a received reply is learned even when it targets us, and never answered
    word_q.push_back(arp_packet(ARP_OP_REPLY, 48'h1234_5678_9ABC, 32'h0102_0304, my_ip));
    word_q.push_back(arp_query(OP_LOOKUP, 32'h0102_0304));
    // byte-reversed address hashes to the same slot and evicts the first one
    word_q.push_back(arp_packet(ARP_OP_REQUEST, 48'hA5A5_A5A5_A5A5, 32'h0403_0201, 32'h0));
    word_q.push_back(arp_query(OP_LOOKUP, 32'h0102_0304));
    word_q.push_back(arp_query(OP_LOOKUP, 32'h0403_0201));
    // dropped packets: each header check and bad opcodes, all for us
    begin
      arp_word_t bad;
      for (int k = 0; k < 7; k++) begin
        bad = arp_packet(ARP_OP_REQUEST, 48'h5A5A_5A5A_5A5A, 32'h0A0B_0C0D, my_ip);
        case (k)
          0: bad.hw_type    = 16'hFFFF;
          1: bad.proto_type = 16'h86DD;
          2: bad.hw_len     = 8'hFF;
          3: bad.proto_len  = 8'h00;
          4: bad.arp_op     = 16'h0000;
          5: bad.arp_op     = 16'h0003;
          default: bad.arp_op = 16'hFFFF;
        endcase
        word_q.push_back(bad);
      end
    end
    word_q.push_back(arp_query(OP_LOOKUP, 32'h0A0B_0C0D));
    // broadcast requests at both address extremes, then the unused code
    word_q.push_back(arp_query(OP_SEND, 32'h0000_0000));
    word_q.push_back(arp_query(OP_SEND, 32'hFFFF_FFFF));
    word_q.push_back(arp_query(OP_UNUSED, 32'($urandom)));
    word_q.push_back(arp_query(OP_LOOKUP, 32'h0A00_0001));
    wait_drained();

    // all-ones interface addresses; chunks alternate idling, and each drain
    // holds the sender until the block has caught up
    write_reg(CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_OWN_IP, 48'h0000_FFFF_FFFF);
    refresh_pool();
    idle_on = 1'b1;
    run_random(50);
    // long hold-off on the result side while the sender keeps offering
    idle_on = 1'b0;
    hold_off_left = HOLD_OFF_CYCLES;
    run_random(50);
    idle_on = 1'b1;
    run_random(50);
    idle_on = 1'b0;
    run_random(50);

    // all-zero interface addresses
    write_reg(CFG_OWN_IP, 48'h0);
    write_reg(CFG_OWN_MAC, 48'h0);
    refresh_pool();
    idle_on = 1'b1;
    for (int c = 0; c < 3; c++)
      run_random(60);

    // random interface addresses, no idling to the end
    refresh_pool();
    write_reg(CFG_OWN_MAC, rand_mac());
    write_reg(CFG_OWN_IP, 48'(ip_pool[$urandom_range(0, 15)]));
    idle_on = 1'b0;
    run_random(200);

    // let any stray result word show up before the verdict
    repeat (10) @(negedge clk);
    if (reply_due_q.size() != 0)
      flag_mismatch("result words never delivered", 64'(reply_due_q.size()), 64'(0));
    if (err_count == 0)
      $display("tb_arp_responder_with_hashed_cache_core: clean");
    else
      $display("tb_arp_responder_with_hashed_cache_core: errors");
    $finish;
  end

endmodule
